>>> hw/rtl/siim_pkg.sv
// Package for the sorted interval insert/merge block.
// Holds command codes, field widths and the result/action record types.
// No dependencies.
package siim_pkg;

	localparam int FIELD_W         = 32;
	localparam int VAL_MAX_W       = 64;
	localparam int VALUE_WIDTH_DEF = 32;
	localparam int QUEUE_DEPTH_DEF = 4;

	localparam logic CMD_BEGIN = 1'b0;
	localparam logic CMD_LIST  = 1'b1;

	typedef struct packed {
		logic [FIELD_W-1:0] lo;
		logic [FIELD_W-1:0] hi;
		logic               last;
	} siim_res_t;

	// One classified item: up to two results, in emission order.
	typedef struct packed {
		siim_res_t first;
		siim_res_t second;
		logic      two;
	} siim_act_t;

	typedef struct packed {
		logic full;
		logic empty;
	} siim_qstat_t;

endpackage

>>> hw/rtl/siim_front.sv
// Front end: accepts items, tracks the sweep phase and merged block, classifies each item.
// Depends on siim_pkg.
module siim_front
	import siim_pkg::*;
#(
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  logic               command,
	input  logic signed [31:0] lo_bound,
	input  logic signed [31:0] hi_bound,
	input  logic               last_of_list,
	output logic               act_push,
	output siim_act_t          act_data
);

	localparam logic [1:0] PH_IDLE   = 2'd0;
	localparam logic [1:0] PH_BEFORE = 2'd1;
	localparam logic [1:0] PH_MERGE  = 2'd2;
	localparam logic [1:0] PH_AFTER  = 2'd3;

	logic [1:0]             phase_q, phase_d;
	logic [VALUE_WIDTH-1:0] ms_q, me_q, ms_d, me_d;
	logic [VAL_MAX_W-1:0]   lo_x, hi_x;
	logic [VALUE_WIDTH-1:0] lo_v, hi_v;
	logic                   hi_lt_ms, me_lt_lo, lo_lt_ms, me_lt_hi;
	logic [VALUE_WIDTH-1:0] min_s, max_e;

	function automatic logic [FIELD_W-1:0] to_fld(input logic [VALUE_WIDTH-1:0] v);
		logic [VAL_MAX_W-1:0] x;
		x = VAL_MAX_W'(v);
		return x[FIELD_W-1:0];
	endfunction

	function automatic siim_res_t mk_res(input logic [VALUE_WIDTH-1:0] s,
		input logic [VALUE_WIDTH-1:0] e, input logic l);
		siim_res_t r;
		r.lo   = to_fld(s);
		r.hi   = to_fld(e);
		r.last = l;
		return r;
	endfunction

	// Cut or zero-extend the port values to the working width.
	assign lo_x = VAL_MAX_W'($unsigned(lo_bound));
	assign hi_x = VAL_MAX_W'($unsigned(hi_bound));
	assign lo_v = lo_x[VALUE_WIDTH-1:0];
	assign hi_v = hi_x[VALUE_WIDTH-1:0];

	assign hi_lt_ms = $signed(hi_v) < $signed(ms_q);
	assign me_lt_lo = $signed(me_q) < $signed(lo_v);
	assign lo_lt_ms = $signed(lo_v) < $signed(ms_q);
	assign me_lt_hi = $signed(me_q) < $signed(hi_v);
	assign min_s    = lo_lt_ms ? lo_v : ms_q;
	assign max_e    = me_lt_hi ? hi_v : me_q;

	always_comb begin
		phase_d  = phase_q;
		ms_d     = ms_q;
		me_d     = me_q;
		act_push = 1'b0;
		act_data = '0;
		if (accept) begin
			if (command == CMD_BEGIN) begin
				ms_d = lo_v;
				me_d = hi_v;
				if (last_of_list) begin
					act_push       = 1'b1;
					act_data.first = mk_res(lo_v, hi_v, 1'b1);
					phase_d        = PH_IDLE;
				end else begin
					phase_d = PH_BEFORE;
				end
			end else begin
				unique case (phase_q) inside
					PH_BEFORE, PH_MERGE: begin
						if (phase_q == PH_BEFORE && hi_lt_ms) begin
							// Item lies wholly below the block: pass it through.
							act_push       = 1'b1;
							act_data.first = mk_res(lo_v, hi_v, 1'b0);
							if (last_of_list) begin
								act_data.second = mk_res(ms_q, me_q, 1'b1);
								act_data.two    = 1'b1;
								phase_d         = PH_IDLE;
							end
						end else if (!me_lt_lo) begin
							// Overlap: widen the block.
							ms_d    = min_s;
							me_d    = max_e;
							phase_d = PH_MERGE;
							if (last_of_list) begin
								act_push       = 1'b1;
								act_data.first = mk_res(min_s, max_e, 1'b1);
								phase_d        = PH_IDLE;
							end
						end else begin
							// Item lies beyond the block: block first, then item.
							act_push        = 1'b1;
							act_data.first  = mk_res(ms_q, me_q, 1'b0);
							act_data.second = mk_res(lo_v, hi_v, last_of_list);
							act_data.two    = 1'b1;
							phase_d         = last_of_list ? PH_IDLE : PH_AFTER;
						end
					end
					PH_AFTER: begin
						act_push       = 1'b1;
						act_data.first = mk_res(lo_v, hi_v, last_of_list);
						if (last_of_list) begin
							phase_d = PH_IDLE;
						end
					end
					PH_IDLE: begin
						// Drop list items outside an insertion.
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
		end else begin
			phase_q <= phase_d;
		end
	end

	always_ff @(posedge clk) begin
		ms_q <= ms_d;
		me_q <= me_d;
	end

endmodule

>>> hw/rtl/siim_queue.sv
// Short queue of classified actions between front and back.
// Depends on siim_pkg.
module siim_queue
	import siim_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  siim_act_t   din,
	input  logic        pop,
	output siim_act_t   dout,
	output siim_qstat_t stat
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	siim_act_t       mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            do_push, do_pop;

	assign stat.full  = (count_q == CW'(DEPTH));
	assign stat.empty = (count_q == '0);
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign dout       = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

endmodule

>>> hw/rtl/siim_back.sv
// Back end: unpacks each queued action into one or two results and holds them in the output register.
// Depends on siim_pkg.
module siim_back
	import siim_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  siim_act_t   head,
	input  logic        head_valid,
	output logic        head_pop,
	output logic        out_valid,
	output siim_res_t   out_res,
	input  logic        out_pop
);

	logic      valid_q;
	logic      sel_q;
	siim_res_t res_q;
	logic      load;

	assign load      = head_valid && (!valid_q || out_pop);
	assign head_pop  = load && (!head.two || sel_q);
	assign out_valid = valid_q;
	assign out_res   = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			sel_q   <= 1'b0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				sel_q   <= head_pop ? 1'b0 : 1'b1;
			end else if (out_pop) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= sel_q ? head.second : head.first;
		end
	end

endmodule

>>> hw/rtl/sorted_interval_insert_merge.sv
// Sorted interval insert/merge, top level: front classifier, action queue, result back end.
// Depends on siim_pkg, siim_front, siim_queue, siim_back.
// A result passes through the queue and then the output register after the item's transfer.
// Throughput: one item per cycle unless the queue is full (combinational compares in the front);
// one result per cycle leaves the back end while pop is held; a two-result item takes two pops.
// Reset: arst_n clears the phase to idle and empties queue and output register.
module sorted_interval_insert_merge
	import siim_pkg::*;
#(
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic               command,
	input  logic signed [31:0] lo_bound,
	input  logic signed [31:0] hi_bound,
	input  logic               last_of_list,
	output logic               empty,
	input  logic               pop,
	output logic signed [31:0] out_start,
	output logic signed [31:0] out_end,
	output logic               out_last
);

	logic        in_xfer;
	logic        q_push;
	siim_act_t   q_din;
	siim_act_t   q_head;
	logic        q_pop;
	siim_qstat_t q_stat;
	logic        res_valid;
	siim_res_t   res;
	logic        out_xfer;

	// The front only stalls on a full queue; the back drains independently.
	assign full     = q_stat.full;
	assign in_xfer  = push && !full;
	assign out_xfer = pop && !empty;

	siim_front #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (in_xfer),
		.command     (command),
		.lo_bound    (lo_bound),
		.hi_bound    (hi_bound),
		.last_of_list(last_of_list),
		.act_push    (q_push),
		.act_data    (q_din)
	);

	// Items that produce no result are never queued.
	siim_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (q_push),
		.din   (q_din),
		.pop   (q_pop),
		.dout  (q_head),
		.stat  (q_stat)
	);

	// Hold each result in the output register until its transfer completes.
	siim_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (q_head),
		.head_valid(!q_stat.empty),
		.head_pop  (q_pop),
		.out_valid (res_valid),
		.out_res   (res),
		.out_pop   (out_xfer)
	);

	assign empty     = !res_valid;
	assign out_start = $signed(res.lo);
	assign out_end   = $signed(res.hi);
	assign out_last  = res.last;

	// The queue is never full and empty at once.
	a_q_state: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_stat.full && q_stat.empty))
		else $error("queue reports full and empty together");

	// The front only pushes while the queue has room.
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_stat.full)
		else $error("front pushed into a full queue");

	// The back only retires an action that is present.
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_stat.empty)
		else $error("back popped an empty queue");

	// A waiting result is never dropped without a transfer.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> !empty)
		else $error("waiting result vanished");

endmodule

>>> tb/sorted_interval_insert_merge_tb.sv
// Self-checking testbench for sorted_interval_insert_merge.
// It runs a directed stimulus table, then random interval lists checked by a built-in predictor.
// Depends on siim_pkg and the sorted_interval_insert_merge RTL.
module sorted_interval_insert_merge_tb;
	import siim_pkg::*;

	typedef longint unsigned u64_t;

	// Sweep phase of one insertion, as seen from outside the block.
	typedef enum logic [1:0] {
		SWEEP_IDLE,
		SWEEP_BEFORE,
		SWEEP_MERGE,
		SWEEP_AFTER
	} sweep_t;

	// One emitted interval of the merged output list.
	typedef struct packed {
		logic signed [31:0] start_v;
		logic signed [31:0] stop_v;
		logic               last_v;
	} interval_t;

	// One row of stimulus. Rows marked fixed carry the results to expect;
	// all other rows are checked against the predictor.
	typedef struct packed {
		logic               cmd;
		logic signed [31:0] lo;
		logic signed [31:0] hi;
		logic               last;
		logic               fixed;
		logic [1:0]         n_fixed;
		interval_t          r0;
		interval_t          r1;
	} stim_row_t;

	localparam logic signed [31:0] S_MIN = 32'sh8000_0000;
	localparam logic signed [31:0] S_MAX = 32'sh7fff_ffff;
	localparam longint L_MIN = -64'sd2147483648;
	localparam longint L_MAX = 64'sd2147483647;
	localparam int RANDOM_ITEMS = 1400;
	localparam int DRAIN_EVERY = 300;
	localparam int TAIL_CYCLES = 16;

	logic               clk;
	logic               arst_n       = 1'b0;
	logic               push         = 1'b0;
	logic               full;
	logic               command      = CMD_BEGIN;
	logic signed [31:0] lo_bound     = '0;
	logic signed [31:0] hi_bound     = '0;
	logic               last_of_list = 1'b0;
	logic               empty;
	logic               pop          = 1'b0;
	logic signed [31:0] out_start;
	logic signed [31:0] out_end;
	logic               out_last;

	// Predictor state: its own copy of the phase and the merged block.
	sweep_t             sweep_q    = SWEEP_IDLE;
	logic signed [31:0] merged_lo  = '0;
	logic signed [31:0] merged_hi  = '0;

	// Intervals still owed by the block, oldest first.
	interval_t          owed_q[$];
	interval_t          head_r;
	int                 fail_cnt   = 0;
	int                 useful_cnt = 0;

	// Idle control for both sides.
	bit                 send_burst = 1'b0;
	bit                 pop_burst  = 1'b0;
	int                 pop_gap    = 0;
	int                 pop_cycle  = 0;

	sorted_interval_insert_merge u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.command      (command),
		.lo_bound     (lo_bound),
		.hi_bound     (hi_bound),
		.last_of_list (last_of_list),
		.empty        (empty),
		.pop          (pop),
		.out_start    (out_start),
		.out_end      (out_end),
		.out_last     (out_last)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Pick an idle stretch: mostly none or short, now and then a long one.
	function automatic int idle_len();
		int p;
		p = $urandom_range(0, 99);
		if (p < 60)
			return 0;
		if (p < 90)
			return $urandom_range(1, 3);
		if (p < 98)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	function automatic interval_t ival(logic signed [31:0] s, logic signed [31:0] e, logic l);
		interval_t r;
		r.start_v = s;
		r.stop_v  = e;
		r.last_v  = l;
		return r;
	endfunction

	function automatic stim_row_t mk(logic c, logic signed [31:0] l, logic signed [31:0] h,
			logic la);
		stim_row_t r;
		r      = '0;
		r.cmd  = c;
		r.lo   = l;
		r.hi   = h;
		r.last = la;
		return r;
	endfunction

	function automatic stim_row_t mk_fixed(logic c, logic signed [31:0] l,
			logic signed [31:0] h, logic la, logic [1:0] n, interval_t a, interval_t b);
		stim_row_t r;
		r         = mk(c, l, h, la);
		r.fixed   = 1'b1;
		r.n_fixed = n;
		r.r0      = a;
		r.r1      = b;
		return r;
	endfunction

	function automatic logic signed [31:0] clamp32(longint v);
		if (v < L_MIN)
			return S_MIN;
		if (v > L_MAX)
			return S_MAX;
		return 32'(v);
	endfunction

	// Work out the intervals one transferred item makes, in emission order,
	// and advance the predictor's phase and merged block.
	function automatic void predict_intervals(input logic cmd, input logic signed [31:0] lo,
			input logic signed [31:0] hi, input logic last,
			output interval_t r0, output interval_t r1, output int n);
		n  = 0;
		r0 = '0;
		r1 = '0;
		if (cmd == CMD_BEGIN) begin
			// A begin always restarts; an unfinished list is dropped silently.
			useful_cnt++;
			merged_lo = lo;
			merged_hi = hi;
			if (last) begin
				// Empty list: the new interval is the whole output.
				r0      = ival(lo, hi, 1'b1);
				n       = 1;
				sweep_q = SWEEP_IDLE;
			end else begin
				sweep_q = SWEEP_BEFORE;
			end
			return;
		end
		if (sweep_q == SWEEP_IDLE)
			return;
		useful_cnt++;
		if (sweep_q == SWEEP_AFTER) begin
			r0 = ival(lo, hi, last);
			n  = 1;
			if (last)
				sweep_q = SWEEP_IDLE;
			return;
		end
		if (sweep_q == SWEEP_BEFORE && hi < merged_lo) begin
			// Item ends below the block: pass it, and close with the block if last.
			r0 = ival(lo, hi, 1'b0);
			n  = 1;
			if (last) begin
				r1      = ival(merged_lo, merged_hi, 1'b1);
				n       = 2;
				sweep_q = SWEEP_IDLE;
			end
			return;
		end
		if (!(merged_hi < lo)) begin
			// Overlap: widen the block.
			if (lo < merged_lo)
				merged_lo = lo;
			if (merged_hi < hi)
				merged_hi = hi;
			sweep_q = SWEEP_MERGE;
			if (last) begin
				r0      = ival(merged_lo, merged_hi, 1'b1);
				n       = 1;
				sweep_q = SWEEP_IDLE;
			end
			return;
		end
		// Item lies beyond the block: the block goes out first, then the item.
		r0      = ival(merged_lo, merged_hi, 1'b0);
		r1      = ival(lo, hi, last);
		n       = 2;
		sweep_q = last ? SWEEP_IDLE : SWEEP_AFTER;
	endfunction

	// Offer one item, hold it until the block takes it, then record what it owes.
	// Push stays high into the next item when no gap is drawn.
	task automatic send_row(input stim_row_t row);
		int        gap;
		int        n;
		interval_t r0;
		interval_t r1;
		gap = send_burst ? 0 : idle_len();
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push         <= 1'b1;
		command      <= row.cmd;
		lo_bound     <= row.lo;
		hi_bound     <= row.hi;
		last_of_list <= row.last;
		@(posedge clk);
		while (full)
			@(posedge clk);
		predict_intervals(row.cmd, row.lo, row.hi, row.last, r0, r1, n);
		if (row.fixed) begin
			n  = row.n_fixed;
			r0 = row.r0;
			r1 = row.r1;
		end
		if (n > 0)
			owed_q = {owed_q, r0};
		if (n > 1)
			owed_q = {owed_q, r1};
	endtask

	// Drop push and hold until every owed interval has been popped.
	task automatic drain();
		push <= 1'b0;
		do
			@(posedge clk);
		while (owed_q.size() != 0);
	endtask

	// One random insertion: a sorted disjoint list around a new interval.
	// Broken sequences stop early without a last item, so the next begin abandons them.
	task automatic send_sequence(input bit broken);
		longint    llo[10];
		longint    lhi[10];
		longint    cur;
		longint    unit;
		longint    lo;
		longint    hi;
		longint    lo0;
		longint    hi0;
		longint    a;
		longint    b;
		longint    t;
		u64_t      rnd;
		int        n;
		int        len;
		int        cut;
		int        mode;
		mode = $urandom_range(0, 9);
		if (mode < 2) begin
			// Wide spread: the list starts near the negative extreme and may cross zero.
			unit = 64'sd1 << 26;
			cur  = L_MIN - 1 + $urandom_range(0, 3) * unit;
		end else if (mode == 2) begin
			unit = 4;
			cur  = $urandom_range(0, 1) ? L_MIN - 1 : L_MAX - 60;
		end else begin
			unit = 8;
			cur  = longint'($signed($urandom));
			if (cur > L_MAX - 1000)
				cur = cur - 2000;
		end
		len = $urandom_range(0, 8);
		n   = 0;
		for (int k = 0; k < len; k++) begin
			lo = cur + $urandom_range(1, int'(3 * unit));
			if (lo > L_MAX)
				break;
			hi = lo + $urandom_range(0, int'(2 * unit));
			if (hi > L_MAX)
				hi = L_MAX;
			llo[n] = lo;
			lhi[n] = hi;
			n++;
			cur = hi + 1;
			if (hi == L_MAX)
				break;
		end
		// New interval lands somewhere over the list, or a little past either end.
		lo0 = (n > 0 ? llo[0] : cur) - 4 * unit;
		hi0 = (n > 0 ? lhi[n-1] : cur) + 4 * unit;
		rnd = u64_t'($urandom);
		rnd = (rnd << 32) | u64_t'($urandom);
		a   = lo0 + longint'(rnd % u64_t'(hi0 - lo0 + 1));
		b   = a + $urandom_range(0, int'(4 * unit));
		if ($urandom_range(0, 9) == 0) begin
			t = a;
			a = b;
			b = t;
		end
		send_burst = ($urandom_range(0, 4) == 0);
		send_row(mk(CMD_BEGIN, clamp32(a), clamp32(b), (n == 0) && !broken));
		cut = broken ? (n > 0 ? $urandom_range(0, n - 1) : 0) : n;
		for (int k = 0; k < cut; k++)
			send_row(mk(CMD_LIST, clamp32(llo[k]), clamp32(lhi[k]),
					!broken && (k == n - 1)));
	endtask

	// Result side: check each transfer against the oldest owed interval,
	// then decide pop for the next cycle with one assignment.
	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			if (owed_q.size() == 0) begin
				$error("unexpected result: out_start %0d out_end %0d out_last %0b",
						out_start, out_end, out_last);
				fail_cnt++;
			end else begin
				head_r = owed_q.pop_front();
				if (out_start !== head_r.start_v) begin
					$error("out_start: expected %0d, got %0d", head_r.start_v, out_start);
					fail_cnt++;
				end
				if (out_end !== head_r.stop_v) begin
					$error("out_end: expected %0d, got %0d", head_r.stop_v, out_end);
					fail_cnt++;
				end
				if (out_last !== head_r.last_v) begin
					$error("out_last: expected %0b, got %0b", head_r.last_v, out_last);
					fail_cnt++;
				end
			end
		end
		// Now and then switch into or out of a stretch with no stalls.
		pop_cycle++;
		if (pop_cycle % 256 == 0)
			pop_burst = ($urandom_range(0, 3) == 0);
		if (pop_gap > 0) begin
			pop_gap--;
			pop <= 1'b0;
		end else begin
			pop <= 1'b1;
			if (!pop_burst)
				pop_gap = idle_len();
		end
	end

	// Hard stop in case the block hangs.
	initial begin
		#10_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		stim_row_t dir_rows[$];
		int        next_drain;
		int        p;
		// Directed rows. Fixed expectations only where they are obvious.
		// A list item right after reset is ignored.
		dir_rows = {dir_rows, mk_fixed(CMD_LIST, 1, 2, 1'b0, 2'd0, '0, '0)};
		// Empty list at the extremes goes out at once, flagged last.
		dir_rows = {dir_rows, mk_fixed(CMD_BEGIN, S_MIN, S_MAX, 1'b1, 2'd1,
				ival(S_MIN, S_MAX, 1'b1), '0)};
		// A list item after the list has ended is ignored.
		dir_rows = {dir_rows, mk_fixed(CMD_LIST, 5, 5, 1'b1, 2'd0, '0, '0)};
		dir_rows = {dir_rows, mk_fixed(CMD_BEGIN, S_MAX, S_MIN, 1'b1, 2'd1,
				ival(S_MAX, S_MIN, 1'b1), '0)};
		// Full walk: before, merge twice, block then item, last item after.
		dir_rows = {dir_rows, mk(CMD_BEGIN, 10, 20, 1'b0)};
		dir_rows = {dir_rows, mk(CMD_LIST, 1, 3, 1'b0)};
		dir_rows = {dir_rows, mk(CMD_LIST, 5, 12, 1'b0)};
		dir_rows = {dir_rows, mk(CMD_LIST, 15, 18, 1'b0)};
		dir_rows = {dir_rows, mk(CMD_LIST, 25, 30, 1'b0)};
		dir_rows = {dir_rows, mk(CMD_LIST, 40, 50, 1'b1)};
		// Last item below the block, then overlapping it.
		dir_rows = {dir_rows, mk(CMD_BEGIN, 100, 200, 1'b0)};
		dir_rows = {dir_rows, mk(CMD_LIST, 0, 10, 1'b1)};
		dir_rows = {dir_rows, mk(CMD_BEGIN, 100, 200, 1'b0)};
		dir_rows = {dir_rows, mk(CMD_LIST, 150, 300, 1'b1)};
		// Item touching the block start merges.
		dir_rows = {dir_rows, mk(CMD_BEGIN, 10, 20, 1'b0)};
		dir_rows = {dir_rows, mk(CMD_LIST, 5, 10, 1'b1)};
		// Extreme list items around a zero block.
		dir_rows = {dir_rows, mk(CMD_BEGIN, 0, 0, 1'b0)};
		dir_rows = {dir_rows, mk(CMD_LIST, S_MIN, S_MIN, 1'b0)};
		dir_rows = {dir_rows, mk(CMD_LIST, S_MAX, S_MAX, 1'b1)};
		// Begin in the middle of a list abandons it.
		dir_rows = {dir_rows, mk(CMD_BEGIN, 5, 6, 1'b0)};
		dir_rows = {dir_rows, mk(CMD_LIST, 1, 2, 1'b0)};
		dir_rows = {dir_rows, mk(CMD_BEGIN, 50, 60, 1'b0)};
		dir_rows = {dir_rows, mk(CMD_LIST, 55, 70, 1'b1)};
		// Inverted list item goes through the same compares.
		dir_rows = {dir_rows, mk(CMD_BEGIN, 10, 20, 1'b0)};
		dir_rows = {dir_rows, mk(CMD_LIST, 30, 5, 1'b1)};
		dir_rows = {dir_rows, mk(CMD_BEGIN, S_MIN, S_MIN, 1'b0)};
		dir_rows = {dir_rows, mk(CMD_LIST, S_MIN, S_MAX, 1'b1)};

		// Hold reset at the start, then release it for good.
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			send_row(dir_rows[i]);

		// Random part: mostly well-formed lists, some broken ones and raw noise.
		useful_cnt = 0;
		next_drain = DRAIN_EVERY;
		while (useful_cnt < RANDOM_ITEMS) begin
			p = $urandom_range(0, 99);
			if (p < 12) begin
				send_burst = 1'b0;
				send_row(mk(logic'($urandom_range(0, 1)), $signed($urandom),
						$signed($urandom), logic'($urandom_range(0, 1))));
			end else begin
				send_sequence(p < 22);
			end
			// Pause the sender until the block has caught up.
			if (useful_cnt >= next_drain) begin
				drain();
				next_drain += DRAIN_EVERY;
			end
		end

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_cnt == 0 && owed_q.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

>>> sim.f
hw/rtl/siim_pkg.sv
hw/rtl/siim_front.sv
hw/rtl/siim_queue.sv
hw/rtl/siim_back.sv
hw/rtl/sorted_interval_insert_merge.sv
tb/sorted_interval_insert_merge_tb.sv
